// ===== design/natt_pkg.sv =====
// Shared types, widths and codes for the NAT translation table.
package natt_pkg;

  localparam int unsigned NATT_TABLE_DEPTH = 16;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned PROTO_W     = 8;
  localparam int unsigned IDENT_W     = 16;
  localparam int unsigned IFACE_W     = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_IDX_W = 4;
  localparam int unsigned PREFIX_W    = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [PROTO_W-1:0] PROTO_ICMP6 = 8'd58;
  localparam logic [PROTO_W-1:0] PROTO_UDP   = 8'd17;
  localparam logic [IDENT_W-1:0] ID_START    = 16'h0080;

  typedef enum logic {
    OP_OUTBOUND = 1'b0,
    OP_INBOUND  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_TRANSLATED = 2'd0,
    ST_INSIDE     = 2'd1,
    ST_FULL       = 2'd2,
    ST_NO_MATCH   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAT_HIGH = 2'd0,
    CFG_NAT_LOW  = 2'd1,
    CFG_PREFIX_A = 2'd2,
    CFG_PREFIX_B = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RES_OUT_XLATE = 3'd0,
    RES_INSIDE    = 3'd1,
    RES_FULL      = 3'd2,
    RES_IN_XLATE  = 3'd3,
    RES_NO_MATCH  = 3'd4
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     scan_clr;
    logic     scan_inc;
    logic     rd_issue;
    logic     commit;
    res_sel_e res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_inbound;
    logic inside_hit;
    logic proto_ok;
    logic free_hit;
    logic scan_last;
    logic cmp_valid;
    logic cmp_hit;
    logic cmp_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/natt_if.sv =====
// Request and result channel interfaces of the NAT translation table.
interface natt_in_if;
  import natt_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [ADDR_W-1:0]  src_high;
  logic [ADDR_W-1:0]  src_low;
  logic [ADDR_W-1:0]  dst_high;
  logic [ADDR_W-1:0]  dst_low;
  logic [PROTO_W-1:0] next_header;
  logic [IDENT_W-1:0] ident_port;
  logic [IFACE_W-1:0] in_iface;

  modport source (
    output valid, op, src_high, src_low, dst_high, dst_low, next_header, ident_port,
           in_iface,
    input  ready
  );
  modport sink (
    input  valid, op, src_high, src_low, dst_high, dst_low, next_header, ident_port,
           in_iface,
    output ready
  );
endinterface

interface natt_out_if;
  import natt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [ADDR_W-1:0]      new_addr_high;
  logic [ADDR_W-1:0]      new_addr_low;
  logic [IDENT_W-1:0]     new_ident;
  logic [IFACE_W-1:0]     new_iface;
  logic [ENTRY_IDX_W-1:0] entry_index;

  modport source (
    output valid, status, new_addr_high, new_addr_low, new_ident, new_iface, entry_index,
    input  ready
  );
  modport sink (
    input  valid, status, new_addr_high, new_addr_low, new_ident, new_iface, entry_index,
    output ready
  );
endinterface

// ===== design/nat_translation_table.sv =====
// Top level of the NAT translation table.
// The engine handles one request at a time. An outbound request checks one table entry a
// cycle while looking for the lowest free entry, and an inbound request walks the entry
// memory through its single registered read port, one entry a cycle. Inside destinations
// and inbound packets that are neither ICMPv6 nor UDP are answered without a table scan.
// A finished result sits in the output register until it is taken, and the next request
// is accepted once the result has been loaded there. Configuration writes take effect at
// once and are expected only while no request is outstanding; entries are valid only once
// allocated, so no clearing pass is needed after reset.
module nat_translation_table #(
  parameter int unsigned TABLE_DEPTH = natt_pkg::NATT_TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [natt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [natt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  natt_in_if.sink                         in_i,
  natt_out_if.source                      out_o
);
  import natt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  natt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  natt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

`ifndef SYNTHESIS
  // A result is only committed when the output register can take it.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result committed while the output register was occupied");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("committed result not presented on the output");

  // Once a request is taken the engine is busy until its result is loaded.
  a_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_i.ready)
    else $error("new request accepted while one is in progress");
`endif

endmodule

// ===== design/natt_ctrl.sv =====
// Sequencing state machine of the NAT translation table.
module natt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  natt_pkg::sts_t sts_i,
  output natt_pkg::cmd_t cmd_o
);
  import natt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SCAN_OUT,
    S_SCAN_IN,
    S_FINISH
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_sel_q, res_sel_d;

  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = res_sel_q;
    state_d       = state_q;
    res_sel_d     = res_sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.capture  = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (!sts_i.is_inbound) begin
          if (sts_i.inside_hit) begin
            res_sel_d = RES_INSIDE;
            state_d   = S_FINISH;
          end else begin
            state_d = S_SCAN_OUT;
          end
        end else if (sts_i.proto_ok) begin
          state_d = S_SCAN_IN;
        end else begin
          res_sel_d = RES_NO_MATCH;
          state_d   = S_FINISH;
        end
      end
      S_SCAN_OUT: begin
        if (sts_i.free_hit) begin
          res_sel_d = RES_OUT_XLATE;
          state_d   = S_FINISH;
        end else if (sts_i.scan_last) begin
          res_sel_d = RES_FULL;
          state_d   = S_FINISH;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_SCAN_IN: begin
        // Reads are issued one entry ahead of the compare.
        if (sts_i.cmp_hit) begin
          res_sel_d = RES_IN_XLATE;
          state_d   = S_FINISH;
        end else if (sts_i.cmp_valid && sts_i.cmp_last) begin
          res_sel_d = RES_NO_MATCH;
          state_d   = S_FINISH;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_sel_q <= RES_NO_MATCH;
    end else begin
      state_q   <= state_d;
      res_sel_q <= res_sel_d;
    end
  end

endmodule

// ===== design/natt_dp.sv =====
// Datapath of the NAT translation table: registers, entry memory and result register.
module natt_dp #(
  parameter int unsigned TABLE_DEPTH = natt_pkg::NATT_TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [natt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [natt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  natt_in_if.sink                         in_i,
  natt_out_if.source                      out_o,
  input  natt_pkg::cmd_t                  cmd_i,
  output natt_pkg::sts_t                  sts_o
);
  import natt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [ADDR_W-1:0]  local_high;
    logic [ADDR_W-1:0]  local_low;
    logic [ADDR_W-1:0]  remote_high;
    logic [ADDR_W-1:0]  remote_low;
    logic [PROTO_W-1:0] proto;
    logic [IFACE_W-1:0] iface;
    logic [IDENT_W-1:0] local_id;
    logic [IDENT_W-1:0] remote_id;
  } entry_t;

  // Configuration registers.
  logic [ADDR_W-1:0]   nat_high_q, nat_low_q;
  logic [PREFIX_W-1:0] prefix_a_q, prefix_b_q;

  // Captured request.
  op_e                op_q;
  logic [ADDR_W-1:0]  src_high_q, src_low_q, dst_high_q, dst_low_q;
  logic [PROTO_W-1:0] nh_q;
  logic [IDENT_W-1:0] idp_q;
  logic [IFACE_W-1:0] iface_q;

  // Table state.
  logic [TABLE_DEPTH-1:0] used_q;
  logic [IDENT_W-1:0]     id_cnt_q;
  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_q;
  entry_t                 wr_entry;
  logic [IDX_W-1:0]       scan_idx_q, cmp_idx_q;
  logic                   cmp_valid_q;

  // Result register.
  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic [ADDR_W-1:0]      addr_high_q, addr_high_d, addr_low_q, addr_low_d;
  logic [IDENT_W-1:0]     ident_q, ident_d;
  logic [IFACE_W-1:0]     oiface_q, oiface_d;
  logic [ENTRY_IDX_W-1:0] eidx_q, eidx_d;

  logic proto_ok, commit_out, commit_in, rd_match;

  assign proto_ok   = (nh_q == PROTO_ICMP6) || (nh_q == PROTO_UDP);
  assign commit_out = cmd_i.commit && (cmd_i.res_sel == RES_OUT_XLATE);
  assign commit_in  = cmd_i.commit && (cmd_i.res_sel == RES_IN_XLATE);
  assign rd_match   = (rd_q.remote_high == src_high_q) && (rd_q.remote_low == src_low_q) &&
                      (rd_q.proto == nh_q) && (rd_q.remote_id == idp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nat_high_q <= '0;
      nat_low_q  <= '0;
      prefix_a_q <= '0;
      prefix_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NAT_HIGH: nat_high_q <= cfg_data_i;
        CFG_NAT_LOW:  nat_low_q  <= cfg_data_i;
        CFG_PREFIX_A: prefix_a_q <= cfg_data_i[PREFIX_W-1:0];
        CFG_PREFIX_B: prefix_b_q <= cfg_data_i[PREFIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_e'(in_i.op);
      src_high_q <= in_i.src_high;
      src_low_q  <= in_i.src_low;
      dst_high_q <= in_i.dst_high;
      dst_low_q  <= in_i.dst_low;
      nh_q       <= in_i.next_header;
      idp_q      <= in_i.ident_port;
      iface_q    <= in_i.in_iface;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      scan_idx_q  <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_inc || cmd_i.rd_issue) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.rd_issue) begin
        cmp_idx_q   <= scan_idx_q;
        cmp_valid_q <= 1'b1;
      end
    end
  end

  always_comb begin
    wr_entry.local_high  = src_high_q;
    wr_entry.local_low   = src_low_q;
    wr_entry.remote_high = dst_high_q;
    wr_entry.remote_low  = dst_low_q;
    wr_entry.proto       = nh_q;
    wr_entry.iface       = iface_q;
    wr_entry.local_id    = idp_q;
    wr_entry.remote_id   = id_cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (commit_out) begin
      mem_q[scan_idx_q] <= wr_entry;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      id_cnt_q <= ID_START;
    end else begin
      if (commit_out) begin
        used_q[scan_idx_q] <= 1'b1;
        id_cnt_q           <= id_cnt_q + 1'b1;
      end
      if (commit_in) begin
        used_q[cmp_idx_q] <= 1'b0;
      end
    end
  end

  always_comb begin
    status_d    = ST_NO_MATCH;
    addr_high_d = dst_high_q;
    addr_low_d  = dst_low_q;
    ident_d     = idp_q;
    oiface_d    = iface_q;
    eidx_d      = '0;
    case (cmd_i.res_sel) inside
      RES_OUT_XLATE: begin
        status_d    = ST_TRANSLATED;
        addr_high_d = nat_high_q;
        addr_low_d  = nat_low_q;
        ident_d     = proto_ok ? id_cnt_q : idp_q;
        oiface_d    = '0;
        eidx_d      = ENTRY_IDX_W'(scan_idx_q);
      end
      RES_INSIDE, RES_FULL: begin
        status_d    = (cmd_i.res_sel == RES_INSIDE) ? ST_INSIDE : ST_FULL;
        addr_high_d = src_high_q;
        addr_low_d  = src_low_q;
      end
      RES_IN_XLATE: begin
        status_d    = ST_TRANSLATED;
        addr_high_d = rd_q.local_high;
        addr_low_d  = rd_q.local_low;
        ident_d     = rd_q.local_id;
        oiface_d    = rd_q.iface;
        eidx_d      = ENTRY_IDX_W'(cmp_idx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= status_d;
      addr_high_q <= addr_high_d;
      addr_low_q  <= addr_low_d;
      ident_q     <= ident_d;
      oiface_q    <= oiface_d;
      eidx_q      <= eidx_d;
    end
  end

  assign in_i.ready          = cmd_i.in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.new_addr_high = addr_high_q;
  assign out_o.new_addr_low  = addr_low_q;
  assign out_o.new_ident     = ident_q;
  assign out_o.new_iface     = oiface_q;
  assign out_o.entry_index   = eidx_q;

  always_comb begin
    sts_o.in_valid   = in_i.valid;
    sts_o.is_inbound = (op_q == OP_INBOUND);
    sts_o.inside_hit = (dst_high_q[ADDR_W-1 -: PREFIX_W] == prefix_a_q) ||
                       (dst_high_q[ADDR_W-1 -: PREFIX_W] == prefix_b_q);
    sts_o.proto_ok   = proto_ok;
    sts_o.free_hit   = !used_q[scan_idx_q];
    sts_o.scan_last  = (scan_idx_q == LAST_IDX);
    sts_o.cmp_valid  = cmp_valid_q;
    sts_o.cmp_hit    = cmp_valid_q && used_q[cmp_idx_q] && rd_match;
    sts_o.cmp_last   = (cmp_idx_q == LAST_IDX);
    sts_o.out_free   = !out_valid_q || out_o.ready;
  end

endmodule

// ===== sim/tb_nat_translation_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the NAT translation table: predicts every result and compares it.
module tb_nat_translation_table;
  import natt_pkg::*;

  localparam int unsigned DEPTH        = NATT_TABLE_DEPTH;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTED  = 50;

  typedef struct {
    op_e                op;
    logic [ADDR_W-1:0]  src_high;
    logic [ADDR_W-1:0]  src_low;
    logic [ADDR_W-1:0]  dst_high;
    logic [ADDR_W-1:0]  dst_low;
    logic [PROTO_W-1:0] next_header;
    logic [IDENT_W-1:0] ident_port;
    logic [IFACE_W-1:0] in_iface;
  } nat_req_t;

  typedef struct {
    status_e                status;
    logic [ADDR_W-1:0]      addr_high;
    logic [ADDR_W-1:0]      addr_low;
    logic [IDENT_W-1:0]     ident;
    logic [IFACE_W-1:0]     iface;
    logic [ENTRY_IDX_W-1:0] index;
  } nat_res_t;

  // Mirror of the translation table and the queue of results it should produce.
  class nat_table_scoreboard;
    logic [ADDR_W-1:0]   nat_high;
    logic [ADDR_W-1:0]   nat_low;
    logic [PREFIX_W-1:0] prefix_a;
    logic [PREFIX_W-1:0] prefix_b;
    bit                  used     [DEPTH];
    logic [ADDR_W-1:0]   loc_high [DEPTH];
    logic [ADDR_W-1:0]   loc_low  [DEPTH];
    logic [ADDR_W-1:0]   rem_high [DEPTH];
    logic [ADDR_W-1:0]   rem_low  [DEPTH];
    logic [PROTO_W-1:0]  proto    [DEPTH];
    logic [IFACE_W-1:0]  iface    [DEPTH];
    logic [IDENT_W-1:0]  loc_id   [DEPTH];
    logic [IDENT_W-1:0]  rem_id   [DEPTH];
    logic [IDENT_W-1:0]  next_id;
    int unsigned         last_alloc;
    int unsigned         errors;
    nat_res_t            pending_results [$];

    function new();
      nat_high   = '0;
      nat_low    = '0;
      prefix_a   = '0;
      prefix_b   = '0;
      foreach (used[i]) used[i] = 1'b0;
      next_id    = ID_START;
      last_alloc = 0;
      errors     = 0;
    endfunction

    static function bit tracks(logic [PROTO_W-1:0] p);
      return (p == PROTO_ICMP6) || (p == PROTO_UDP);
    endfunction

    // Entries of other protocols can never be released again.
    function int unsigned stuck_entries();
      int unsigned n;
      n = 0;
      foreach (used[i]) if (used[i] && !tracks(proto[i])) n++;
      return n;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_NAT_HIGH: nat_high = value;
        CFG_NAT_LOW:  nat_low  = value;
        CFG_PREFIX_A: prefix_a = value[PREFIX_W-1:0];
        CFG_PREFIX_B: prefix_b = value[PREFIX_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(nat_req_t r);
      nat_res_t            e;
      logic [PREFIX_W-1:0] pfx;
      bit                  found;
      int                  i;
      found   = 1'b0;
      e.index = '0;
      e.ident = r.ident_port;
      e.iface = r.in_iface;
      if (r.op == OP_OUTBOUND) begin
        e.addr_high = r.src_high;
        e.addr_low  = r.src_low;
        pfx = r.dst_high[ADDR_W-1 -: PREFIX_W];
        if (pfx == prefix_a || pfx == prefix_b) begin
          e.status = ST_INSIDE;
        end else begin
          e.status = ST_FULL;
          for (i = 0; i < DEPTH; i++) begin
            if (!found && !used[i]) begin
              found       = 1'b1;
              used[i]     = 1'b1;
              loc_high[i] = r.src_high;
              loc_low[i]  = r.src_low;
              rem_high[i] = r.dst_high;
              rem_low[i]  = r.dst_low;
              proto[i]    = r.next_header;
              iface[i]    = r.in_iface;
              loc_id[i]   = r.ident_port;
              rem_id[i]   = next_id;
              e.status    = ST_TRANSLATED;
              e.addr_high = nat_high;
              e.addr_low  = nat_low;
              e.ident     = tracks(r.next_header) ? next_id : r.ident_port;
              e.iface     = '0;
              e.index     = ENTRY_IDX_W'(i);
              last_alloc  = i;
              next_id     = next_id + 16'd1;
            end
          end
        end
      end else begin
        e.status    = ST_NO_MATCH;
        e.addr_high = r.dst_high;
        e.addr_low  = r.dst_low;
        if (tracks(r.next_header)) begin
          for (i = 0; i < DEPTH; i++) begin
            if (!found && used[i] && rem_high[i] == r.src_high && rem_low[i] == r.src_low &&
                proto[i] == r.next_header && rem_id[i] == r.ident_port) begin
              found       = 1'b1;
              used[i]     = 1'b0;
              e.status    = ST_TRANSLATED;
              e.addr_high = loc_high[i];
              e.addr_low  = loc_low[i];
              e.ident     = loc_id[i];
              e.iface     = iface[i];
              e.index     = ENTRY_IDX_W'(i);
            end
          end
        end
      end
      pending_results.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(nat_res_t got);
      nat_res_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no result outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.addr_high !== want.addr_high)
        report($sformatf("new_addr_high %h, expected %h", got.addr_high, want.addr_high));
      if (got.addr_low !== want.addr_low)
        report($sformatf("new_addr_low %h, expected %h", got.addr_low, want.addr_low));
      if (got.ident !== want.ident)
        report($sformatf("new_ident %h, expected %h", got.ident, want.ident));
      if (got.iface !== want.iface)
        report($sformatf("new_iface %0d, expected %0d", got.iface, want.iface));
      if (got.index !== want.index)
        report($sformatf("entry_index %0d, expected %0d", got.index, want.index));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    idle_en;

  nat_table_scoreboard board;

  natt_in_if  req_if ();
  natt_out_if res_if ();

  nat_translation_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic nat_req_t random_header(op_e op);
    nat_req_t r;
    r.op          = op;
    r.src_high    = {$urandom, $urandom};
    r.src_low     = {$urandom, $urandom};
    r.dst_high    = {$urandom, $urandom};
    r.dst_low     = {$urandom, $urandom};
    r.next_header = PROTO_W'($urandom);
    r.ident_port  = IDENT_W'($urandom);
    r.in_iface    = IFACE_W'($urandom);
    return r;
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    if (board.stuck_entries() < 4 && $urandom_range(0, 24) == 0) return PROTO_W'($urandom);
    return $urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP6;
  endfunction

  // Inbound packet that answers the connection held in entry i.
  function automatic nat_req_t reply_to(int unsigned i);
    nat_req_t r;
    r             = random_header(OP_INBOUND);
    r.src_high    = board.rem_high[i];
    r.src_low     = board.rem_low[i];
    r.next_header = board.proto[i];
    r.ident_port  = board.rem_id[i];
    return r;
  endfunction

  function automatic nat_req_t random_request();
    nat_req_t    r;
    int unsigned roll;
    int unsigned live [$];
    for (int i = 0; i < DEPTH; i++)
      if (board.used[i] && nat_table_scoreboard::tracks(board.proto[i])) live.push_back(i);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r = random_header(OP_OUTBOUND);
      r.next_header = pick_proto();
    end else if (roll < 55) begin
      r = random_header(OP_OUTBOUND);
      r.dst_high[ADDR_W-1 -: PREFIX_W] = $urandom_range(0, 1) ? board.prefix_a : board.prefix_b;
      r.next_header = pick_proto();
    end else if (roll < 88 && live.size() != 0) begin
      r = reply_to(live[$urandom_range(0, live.size() - 1)]);
    end else begin
      // Near misses of a live connection, or plain noise.
      r = (live.size() != 0) ? reply_to(live[$urandom_range(0, live.size() - 1)])
                             : random_header(OP_INBOUND);
      case ($urandom_range(0, 3))
        0:       r = random_header(OP_INBOUND);
        1:       r.src_low = r.src_low ^ (64'd1 << $urandom_range(0, 63));
        2:       r.ident_port = r.ident_port + 16'd1;
        default: r.next_header = PROTO_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic send_request(nat_req_t r);
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.op          = r.op;
    req_if.src_high    = r.src_high;
    req_if.src_low     = r.src_low;
    req_if.dst_high    = r.dst_high;
    req_if.dst_low     = r.dst_low;
    req_if.next_header = r.next_header;
    req_if.ident_port  = r.ident_port;
    req_if.in_iface    = r.in_iface;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(r);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes all four registers; the prefix writes carry junk in the unused upper bits.
  task automatic load_settings(logic [ADDR_W-1:0] nat_high, logic [ADDR_W-1:0] nat_low,
                               logic [PREFIX_W-1:0] pfx_a, logic [PREFIX_W-1:0] pfx_b);
    logic [CFG_DATA_W-1:0] word_a;
    logic [CFG_DATA_W-1:0] word_b;
    word_a = {$urandom, $urandom};
    word_b = {$urandom, $urandom};
    word_a[PREFIX_W-1:0] = pfx_a;
    word_b[PREFIX_W-1:0] = pfx_b;
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_NAT_HIGH;
    cfg_data_i = nat_high;
    @(negedge clk_i);
    cfg_idx_i  = CFG_NAT_LOW;
    cfg_data_i = nat_low;
    @(negedge clk_i);
    cfg_idx_i  = CFG_PREFIX_A;
    cfg_data_i = word_a;
    @(negedge clk_i);
    cfg_idx_i  = CFG_PREFIX_B;
    cfg_data_i = word_b;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    board.set_reg(CFG_NAT_HIGH, nat_high);
    board.set_reg(CFG_NAT_LOW, nat_low);
    board.set_reg(CFG_PREFIX_A, word_a);
    board.set_reg(CFG_PREFIX_B, word_b);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else begin
        res_if.ready = 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    nat_res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.status    = status_e'(res_if.status);
      got.addr_high = res_if.new_addr_high;
      got.addr_low  = res_if.new_addr_low;
      got.ident     = res_if.new_ident;
      got.iface     = res_if.new_iface;
      got.index     = res_if.entry_index;
      board.check_result(got);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    nat_req_t    r;
    int unsigned pairs;
    board              = new();
    idle_en            = 1'b1;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_NAT_HIGH;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_OUTBOUND;
    req_if.src_high    = '0;
    req_if.src_low     = '0;
    req_if.dst_high    = '0;
    req_if.dst_low     = '0;
    req_if.next_header = '0;
    req_if.ident_port  = '0;
    req_if.in_iface    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    load_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'hFD00, 16'hFE80);

    // Inside destinations on both prefixes pass untouched.
    r = random_header(OP_OUTBOUND);
    r.src_high = '1;
    r.src_low = '1;
    r.dst_high = {16'hFD00, 48'h0};
    r.ident_port = '1;
    r.in_iface = 2'd3;
    send_request(r);
    r = random_header(OP_OUTBOUND);
    r.src_high = '0;
    r.src_low = '0;
    r.dst_high = {16'hFE80, 48'hFFFF_FFFF_FFFF};
    r.dst_low = '1;
    r.ident_port = '0;
    r.in_iface = 2'd0;
    send_request(r);

    // UDP entry from interface 3, an ICMPv6 entry and an entry of another protocol.
    r = random_header(OP_OUTBOUND);
    r.src_high = '1;
    r.src_low = '1;
    r.dst_high = '1;
    r.dst_low = '1;
    r.next_header = PROTO_UDP;
    r.ident_port = '1;
    r.in_iface = 2'd3;
    send_request(r);
    r = random_header(OP_OUTBOUND);
    r.src_high = '0;
    r.src_low = '0;
    r.dst_high = {16'h2001, 48'h0};
    r.dst_low = '0;
    r.next_header = PROTO_ICMP6;
    r.ident_port = '0;
    r.in_iface = 2'd0;
    send_request(r);
    r = random_header(OP_OUTBOUND);
    r.next_header = 8'hFF;
    send_request(r);

    // Near misses: wrong id, wrong protocol, and a reply to the untracked entry.
    r = reply_to(0);
    r.ident_port = r.ident_port + 16'd1;
    send_request(r);
    r = reply_to(0);
    r.next_header = PROTO_ICMP6;
    send_request(r);
    send_request(reply_to(2));

    // Genuine replies release their entries.
    send_request(reply_to(1));
    send_request(reply_to(0));

    // Fill the table until an outbound packet finds it full.
    repeat (DEPTH) begin
      r = random_header(OP_OUTBOUND);
      r.next_header = $urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP6;
      send_request(r);
    end

    for (int i = 0; i < DEPTH; i++)
      if (board.used[i] && nat_table_scoreboard::tracks(board.proto[i]))
        send_request(reply_to(i));

    // Open and close connections back to back.
    idle_en = 1'b0;
    pairs = 16;
    repeat (pairs) begin
      r = random_header(OP_OUTBOUND);
      r.next_header = $urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP6;
      send_request(r);
      if (board.used[board.last_alloc] &&
          nat_table_scoreboard::tracks(board.proto[board.last_alloc]))
        send_request(reply_to(board.last_alloc));
    end
    idle_en = 1'b1;
    wait_results_done();

    load_settings('1, '1, 16'hFFFF, 16'h0000);
    run_random(270);
    wait_results_done();

    load_settings({$urandom, $urandom}, {$urandom, $urandom}, PREFIX_W'($urandom), 16'hFFFF);
    run_random(140);
    wait_results_done();
    run_random(140);
    wait_results_done();

    // The closing stretch runs without idling on either side.
    load_settings('0, {$urandom, $urandom}, 16'h0000, 16'h0000);
    idle_en = 1'b0;
    run_random(230);

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
